// ===== hw/rtl/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants of the HSV/RGB color converter. It holds the
// byte and word types, the register indexes, the hue sectors and the
// pipeline latency.
// ----------------------------------------------------------------------------
package hrc_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [23:0] word_t;

	typedef enum logic [0:0] {
		MODE_RGB = 1'b0,
		MODE_HSV = 1'b1
	} mode_t;

	typedef enum logic [0:0] {
		CFG_CHANNEL_ORDER = 1'b0,
		CFG_GAMMA_ENABLE  = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		logic channel_order;
		logic gamma_enable;
	} cfg_t;

	localparam int unsigned HueSectorSize = 43;
	localparam int unsigned ByteMax       = 255;
	localparam int unsigned Latency       = 4;

endpackage

// ===== hw/rtl/hrc_datapath.sv =====
// ----------------------------------------------------------------------------
// hrc_datapath
// Three register stages of the color conversion. Stage one finds the hue
// sector and fraction and orders the RGB channels, stage two forms the first
// products and the gamma squares, stage three forms the second products. The
// final channel selection and packing is combinational at the output.
// ----------------------------------------------------------------------------
module hrc_datapath (
	input  logic          clk,
	input  hrc_pkg::cfg_t cfg,
	input  logic          mode,
	input  hrc_pkg::byte_t first_value,
	input  hrc_pkg::byte_t second_value,
	input  hrc_pkg::byte_t third_value,
	output hrc_pkg::word_t word
);
	import hrc_pkg::*;

	sector_t    sector_d;
	byte_t      base_d;
	byte_t      rem_d;
	byte_t      frac_d;
	byte_t      ch_d [3];

	logic       mode_s1;
	sector_t    sector_s1;
	byte_t      frac_s1;
	byte_t      sat_s1;
	byte_t      inv_sat_s1;
	logic       gamma_s1;
	byte_t      ch_s1 [3];

	byte_t      inv_frac;
	logic [8:0] inc [3];
	logic [17:0] sq_full [3];

	logic       mode_s2;
	sector_t    sector_s2;
	logic       grey_s2;
	logic       gamma_s2;
	logic [15:0] sf_s2;
	logic [15:0] sif_s2;
	logic [15:0] p_prod_s2;
	logic [16:0] sq_s2 [3];
	byte_t      ch_s2 [3];

	byte_t      q_fac;
	byte_t      t_fac;
	logic [16:0] sq_dec [3];

	logic       mode_s3;
	sector_t    sector_s3;
	logic       grey_s3;
	byte_t      v_s3;
	byte_t      p_s3;
	logic [15:0] q_prod_s3;
	logic [15:0] t_prod_s3;
	byte_t      rgb_s3 [3];

	byte_t      q_val;
	byte_t      t_val;

	always_comb begin
		if (first_value >= byte_t'(HueSectorSize * 5)) begin
			sector_d = SECTOR_5;
		end else if (first_value >= byte_t'(HueSectorSize * 4)) begin
			sector_d = SECTOR_4;
		end else if (first_value >= byte_t'(HueSectorSize * 3)) begin
			sector_d = SECTOR_3;
		end else if (first_value >= byte_t'(HueSectorSize * 2)) begin
			sector_d = SECTOR_2;
		end else if (first_value >= byte_t'(HueSectorSize)) begin
			sector_d = SECTOR_1;
		end else begin
			sector_d = SECTOR_0;
		end
		case (sector_d)
			SECTOR_1: base_d = byte_t'(HueSectorSize);
			SECTOR_2: base_d = byte_t'(HueSectorSize * 2);
			SECTOR_3: base_d = byte_t'(HueSectorSize * 3);
			SECTOR_4: base_d = byte_t'(HueSectorSize * 4);
			SECTOR_5: base_d = byte_t'(HueSectorSize * 5);
			default:  base_d = '0;
		endcase
		rem_d  = first_value - base_d;
		frac_d = byte_t'({rem_d[5:0], 2'b00}) + byte_t'({rem_d[5:0], 1'b0});
		if (cfg.channel_order) begin
			ch_d[0] = second_value;
			ch_d[1] = first_value;
		end else begin
			ch_d[0] = first_value;
			ch_d[1] = second_value;
		end
		ch_d[2] = third_value;
	end

	always_ff @(posedge clk) begin
		mode_s1    <= mode;
		sector_s1  <= sector_d;
		frac_s1    <= frac_d;
		sat_s1     <= second_value;
		inv_sat_s1 <= byte_t'(ByteMax) - second_value;
		gamma_s1   <= cfg.gamma_enable;
		ch_s1      <= ch_d;
	end

	always_comb begin
		inv_frac = byte_t'(ByteMax) - frac_s1;
		for (int i = 0; i < 3; i++) begin
			inc[i]     = {1'b0, ch_s1[i]} + 9'd1;
			sq_full[i] = 18'(inc[i]) * 18'(inc[i]);
		end
	end

	always_ff @(posedge clk) begin
		mode_s2   <= mode_s1;
		sector_s2 <= sector_s1;
		grey_s2   <= (sat_s1 == '0);
		gamma_s2  <= gamma_s1;
		sf_s2     <= 16'(sat_s1) * 16'(frac_s1);
		sif_s2    <= 16'(sat_s1) * 16'(inv_frac);
		p_prod_s2 <= 16'(ch_s1[2]) * 16'(inv_sat_s1);
		ch_s2     <= ch_s1;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= sq_full[i][16:0];
		end
	end

	always_comb begin
		q_fac = byte_t'(ByteMax) - sf_s2[15:8];
		t_fac = byte_t'(ByteMax) - sif_s2[15:8];
		for (int i = 0; i < 3; i++) begin
			sq_dec[i] = sq_s2[i] - 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3   <= mode_s2;
		sector_s3 <= sector_s2;
		grey_s3   <= grey_s2;
		v_s3      <= ch_s2[2];
		p_s3      <= p_prod_s2[15:8];
		q_prod_s3 <= 16'(ch_s2[2]) * 16'(q_fac);
		t_prod_s3 <= 16'(ch_s2[2]) * 16'(t_fac);
		for (int i = 0; i < 3; i++) begin
			rgb_s3[i] <= gamma_s2 ? sq_dec[i][15:8] : ch_s2[i];
		end
	end

	always_comb begin
		q_val = q_prod_s3[15:8];
		t_val = t_prod_s3[15:8];
		if (mode_s3 == MODE_RGB) begin
			word = {rgb_s3[0], rgb_s3[1], rgb_s3[2]};
		end else if (grey_s3) begin
			word = {v_s3, v_s3, v_s3};
		end else begin
			case (sector_s3)
				SECTOR_0: word = {v_s3, t_val, p_s3};
				SECTOR_1: word = {q_val, v_s3, p_s3};
				SECTOR_2: word = {p_s3, v_s3, t_val};
				SECTOR_3: word = {p_s3, q_val, v_s3};
				SECTOR_4: word = {t_val, p_s3, v_s3};
				default:  word = {v_s3, p_s3, q_val};
			endcase
		end
	end

endmodule

// ===== hw/rtl/hsv_rgb_color_convert.sv =====
// ----------------------------------------------------------------------------
// hsv_rgb_color_convert
// Converts an RGB or HSV color setting into a packed 24-bit LED word.
// ----------------------------------------------------------------------------
// The block takes one word in every clock cycle and never raises busy. Each
// result appears on color_word with done high for exactly one cycle, once the
// word has passed the datapath stages and the output register; the depth is
// set by the HSV path, whose two dependent 8 by 8 multiplications each occupy
// a stage of their own. The receiver cannot stall the results, so it must take
// each one when done is high. The configuration registers should be written
// only while no word is in flight.
module hsv_rgb_color_convert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  hrc_pkg::byte_t      first_value,
	input  hrc_pkg::byte_t      second_value,
	input  hrc_pkg::byte_t      third_value,
	output logic                done,
	output hrc_pkg::word_t      color_word,
	input  logic                wr_en,
	input  hrc_pkg::cfg_index_t wr_index,
	input  logic                wr_data
);
	import hrc_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	logic  valid_s2;
	logic  valid_s3;
	logic  done_q;
	word_t word;
	word_t color_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_CHANNEL_ORDER: cfg_q.channel_order <= wr_data;
				CFG_GAMMA_ENABLE:  cfg_q.gamma_enable  <= wr_data;
			endcase
		end
	end

	hrc_datapath u_datapath (
		.clk          (clk),
		.cfg          (cfg_q),
		.mode         (mode),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.word         (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			color_word_q <= word;
		end
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign color_word = color_word_q;

endmodule

// ===== hw/rtl/hrc_checker.sv =====
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks of the color converter: fixed latency between a taken
// word and its result, and the shape of HSV results.
// ----------------------------------------------------------------------------
module hrc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           mode,
	input hrc_pkg::byte_t second_value,
	input hrc_pkg::byte_t third_value,
	input logic           done,
	input hrc_pkg::word_t color_word
);
	import hrc_pkg::*;

	logic taken;

	assign taken = start && !busy && arst_n;

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(taken, Latency))
		else $error("result strobe without a word taken before");

	a_word_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(taken, Latency) && $past(arst_n, Latency - 1) |-> done)
		else $error("taken word produced no result");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(taken && mode && second_value == '0, Latency)
		|-> color_word == {3{$past(third_value, Latency)}})
		else $error("zero saturation did not give grey");

	a_hsv_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(taken && mode, Latency)
		|-> color_word[23:16] == $past(third_value, Latency)
		|| color_word[15:8] == $past(third_value, Latency)
		|| color_word[7:0] == $past(third_value, Latency))
		else $error("HSV result lacks the value channel");

endmodule

bind hsv_rgb_color_convert hrc_checker u_hrc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HSV/RGB color converter. Color words are sent
// with random gaps. Each accepted word is predicted from its own copy of
// the channel order and gamma settings. Every strobed color word is then
// compared with the oldest prediction. Directed words cover the field
// extremes, every hue sector, grey, and all register settings. Random traffic
// then runs under several register settings.
// ----------------------------------------------------------------------------
module testbench;
	import hrc_pkg::*;

	localparam int unsigned FracScale   = 6;
	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned PhaseWords  = 250;
	localparam int unsigned ReportLimit = 10;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       mode;
	byte_t      first_value;
	byte_t      second_value;
	byte_t      third_value;
	logic       done;
	word_t      color_word;
	logic       wr_en;
	cfg_index_t wr_index;
	logic       wr_data;

	cfg_t        shadow_cfg;
	word_t       expected_words[$];
	int unsigned max_gap;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	hsv_rgb_color_convert i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.done         (done),
		.color_word   (color_word),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				expected_words.size());
			$display("FAIL hsv_rgb_color_convert");
			$finish;
		end
	end

	function automatic word_t pack_channels(int unsigned a, int unsigned b, int unsigned c);
		return {a[7:0], b[7:0], c[7:0]};
	endfunction

	function automatic int unsigned gamma_correct(int unsigned c);
		return (((c + 1) * (c + 1)) - 1) >> 8;
	endfunction

	function automatic word_t predict_color_word(mode_t m, byte_t x, byte_t y, byte_t z);
		int unsigned xv;
		int unsigned yv;
		int unsigned zv;
		int unsigned a;
		int unsigned b;
		int unsigned c;
		int unsigned frac;
		int unsigned p;
		int unsigned q;
		int unsigned t;
		sector_t     sector;
		xv = 32'(x);
		yv = 32'(y);
		zv = 32'(z);
		if (m == MODE_RGB) begin
			a = shadow_cfg.channel_order ? yv : xv;
			b = shadow_cfg.channel_order ? xv : yv;
			c = zv;
			if (shadow_cfg.gamma_enable) begin
				a = gamma_correct(a);
				b = gamma_correct(b);
				c = gamma_correct(c);
			end
			return pack_channels(a, b, c);
		end
		if (yv == 0)
			return pack_channels(zv, zv, zv);
		sector = sector_t'(xv / HueSectorSize);
		frac   = (xv % HueSectorSize) * FracScale;
		p      = (zv * (ByteMax - yv)) >> 8;
		q      = (zv * (ByteMax - ((yv * frac) >> 8))) >> 8;
		t      = (zv * (ByteMax - ((yv * (ByteMax - frac)) >> 8))) >> 8;
		case (sector)
			SECTOR_0: return pack_channels(zv, t, p);
			SECTOR_1: return pack_channels(q, zv, p);
			SECTOR_2: return pack_channels(p, zv, t);
			SECTOR_3: return pack_channels(p, q, zv);
			SECTOR_4: return pack_channels(t, p, zv);
			default:  return pack_channels(zv, p, q);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				if (mismatch_count < ReportLimit)
					$display("unexpected color word %06h", color_word);
				mismatch_count++;
			end else begin
				if (color_word !== expected_words[0]) begin
					if (mismatch_count < ReportLimit)
						$display("color_word mismatch: expected %06h, actual %06h",
							expected_words[0], color_word);
					mismatch_count++;
				end
				void'(expected_words.pop_front());
			end
		end
	end

	task automatic send_word(mode_t m, byte_t x, byte_t y, byte_t z);
		int unsigned gap;
		gap = $urandom_range(max_gap, 0);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		first_value  <= x;
		second_value <= y;
		third_value  <= z;
		do @(posedge clk); while (busy);
		expected_words.push_back(predict_color_word(m, x, y, z));
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CHANNEL_ORDER: shadow_cfg.channel_order = value;
			CFG_GAMMA_ENABLE:  shadow_cfg.gamma_enable  = value;
			default: ;
		endcase
	endtask

	task automatic set_config(logic order, logic gamma_on);
		wait_for_drain();
		write_reg(CFG_CHANNEL_ORDER, order);
		write_reg(CFG_GAMMA_ENABLE, gamma_on);
	endtask

	task automatic test_reset_rgb();
		send_word(MODE_RGB, 8'h00, 8'h00, 8'h00);
		send_word(MODE_RGB, 8'hFF, 8'hFF, 8'hFF);
		send_word(MODE_RGB, 8'h12, 8'h34, 8'h56);
	endtask

	task automatic test_hsv_sectors();
		send_word(MODE_HSV, 8'd100, 8'd0, 8'd200);
		send_word(MODE_HSV, 8'd0, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd42, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd43, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd86, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd129, 8'd200, 8'd255);
		send_word(MODE_HSV, 8'd172, 8'd255, 8'd128);
		send_word(MODE_HSV, 8'd214, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd215, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd255, 8'd255, 8'd255);
		send_word(MODE_HSV, 8'd100, 8'd128, 8'd0);
	endtask

	task automatic test_order_and_gamma();
		set_config(1'b1, 1'b0);
		send_word(MODE_RGB, 8'h12, 8'h34, 8'h56);
		send_word(MODE_HSV, 8'd30, 8'd200, 8'd180);
		set_config(1'b0, 1'b1);
		send_word(MODE_RGB, 8'hFF, 8'h00, 8'h80);
		send_word(MODE_RGB, 8'h01, 8'h02, 8'h03);
		set_config(1'b1, 1'b1);
		send_word(MODE_RGB, 8'hA5, 8'h5A, 8'hFF);
		send_word(MODE_HSV, 8'd250, 8'd255, 8'd255);
	endtask

	task automatic test_random_traffic();
		logic [1:0] phase_cfg[5];
		byte_t      x;
		byte_t      y;
		byte_t      z;
		phase_cfg[0] = 2'b00;
		phase_cfg[1] = 2'b11;
		phase_cfg[2] = 2'b10;
		phase_cfg[3] = 2'b01;
		phase_cfg[4] = 2'($urandom);
		for (int ph = 0; ph < 5; ph++) begin
			set_config(phase_cfg[ph][1], phase_cfg[ph][0]);
			for (int n = 0; n < PhaseWords; n++) begin
				if (n % 50 == 0)
					max_gap = ($urandom_range(2, 0) == 0) ? 0 : 8;
				if (n == PhaseWords / 2)
					wait_for_drain();
				x = 8'($urandom);
				y = ($urandom_range(15, 0) == 0) ? 8'd0 : 8'($urandom);
				z = 8'($urandom);
				if ($urandom_range(7, 0) == 0)
					x = 8'($urandom_range(255, 215));
				send_word(mode_t'($urandom_range(1, 0)), x, y, z);
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		start          <= 1'b0;
		mode           <= MODE_RGB;
		first_value    <= '0;
		second_value   <= '0;
		third_value    <= '0;
		wr_en          <= 1'b0;
		wr_index       <= CFG_CHANNEL_ORDER;
		wr_data        <= 1'b0;
		cycle_count    <= 0;
		shadow_cfg     = '0;
		mismatch_count = 0;
		max_gap        = 8;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_rgb();
		test_hsv_sectors();
		test_order_and_gamma();
		test_random_traffic();
		wait_for_drain();

		if (expected_words.size() != 0) begin
			$display("%0d color words never arrived", expected_words.size());
			mismatch_count += expected_words.size();
		end
		if (mismatch_count == 0)
			$display("PASS hsv_rgb_color_convert");
		else
			$display("FAIL hsv_rgb_color_convert");
		$finish;
	end

endmodule
